// ----- src/heater_pid_onoff_regulator_assert.svh -----
// ----------------------------------------------------------------------------
// Heater regulator assertion macros
// Shared property forms for the regulator checker; clk and rst_n are taken
// from the scope in which a macro is used.
// ----------------------------------------------------------------------------
`ifndef HEATER_PID_ONOFF_REGULATOR_ASSERT_SVH
`define HEATER_PID_ONOFF_REGULATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define HPR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define HPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/hpr_pkg.sv -----
// ----------------------------------------------------------------------------
// Heater regulator package
// Transaction types, register indexes, reset values and fixed-point limits.
// ----------------------------------------------------------------------------
package hpr_pkg;

    // Input transaction: one temperature sample
    typedef struct packed {
        logic signed [15:0] temperature;   // Q8.8 degrees
        logic               first_sample;  // starts a new run
    } sample_t;

    // Output transaction: one heating command
    typedef struct packed {
        logic [14:0] heat_command;  // Q7.8 percent, 0..100
        logic        clamped;
    } result_t;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KP       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KI       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KD       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD   = 3'd5;

    // Register reset values
    localparam logic        RST_MODE     = 1'b1;
    localparam logic [15:0] RST_SETPOINT = 16'd5120;  // 20.0 degrees
    localparam logic [15:0] RST_KP       = 16'd4506;  // about 1.1
    localparam logic [15:0] RST_KI       = 16'd41;    // about 0.01
    localparam logic [15:0] RST_KD       = 16'd614;   // about 0.15
    localparam logic [7:0]  RST_PERIOD   = 8'd10;

    // Mode codes
    localparam logic MODE_ONOFF = 1'b0;
    localparam logic MODE_PID   = 1'b1;

    // Command limits in Q7.8
    localparam logic [14:0] CMD_FULL     = 15'd25600;  // 100 percent
    localparam logic [14:0] CMD_ONOFF_ON = 15'd12800;  // 50 percent
    localparam int          FRAC_SHIFT   = 13;

    // Control total width, in units of 2^-21, and the 100 percent level
    localparam int          TOTAL_W    = 58;
    localparam logic [TOTAL_W-1:0] TOTAL_FULL = TOTAL_W'(25600) << FRAC_SHIFT;

    // Integral saturation bounds (signed 40 bit)
    localparam logic [39:0] INT_MAX40 = {1'b0, {39{1'b1}}};
    localparam logic [39:0] INT_MIN40 = {1'b1, {39{1'b0}}};

endpackage

// ----- src/heater_pid_onoff_regulator.sv -----
// ----------------------------------------------------------------------------
// Heater PID / on-off regulator
// Turns each temperature sample into a 0..100 percent heating command, either
// by on-off comparison against the setpoint or by a PID law with a saturating
// trapezoid integral. Multiplies are shift-add, one multiplier bit per cycle;
// the derivative division is restoring, two quotient bits per cycle.
// ----------------------------------------------------------------------------
// One sample at a time: the sample channel stalls from acceptance until the
// result is handed on. PID runs are paced by the 16-step serial multiplies and
// the 18-step divider; in on-off mode the command is decided in the prep step.
// A stalled result holds the block in its final step until it is taken.
// Reset (rst_n low, asynchronous): registers to their defaults, previous error
// and integral cleared, no result pending.

module heater_pid_onoff_regulator (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample channel
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  hpr_pkg::sample_t                   sample,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output hpr_pkg::result_t                   result,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [hpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import hpr_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_FINAL = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [4:0] MUL_LAST = 5'd15;  // 16 multiplier bits
    localparam logic [4:0] DIV_LAST = 5'd17;  // 36 dividend bits, 2 per step

    // Control and architectural state
    logic [2:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        mode_reg, mode_next;
    logic [15:0] setpoint_reg, setpoint_next;
    logic [15:0] kp_reg, kp_next;
    logic [15:0] ki_reg, ki_next;
    logic [15:0] kd_reg, kd_next;
    logic [7:0]  period_reg, period_next;
    logic [16:0] prev_err_reg, prev_err_next;
    logic [39:0] integral_reg, integral_next;
    logic        out_valid_reg, out_valid_next;

    // Datapath registers
    logic [15:0] temp_reg, temp_next;
    logic        first_reg, first_next;
    logic [16:0] e_reg, e_next;
    logic [17:0] diff_reg, diff_next;
    logic [17:0] sume_reg, sume_next;
    logic [33:0] prod_p_reg, prod_p_next;
    logic [34:0] prod_d_reg, prod_d_next;
    logic [34:0] prod_s_reg, prod_s_next;
    logic [56:0] prod_i_reg, prod_i_next;
    logic [35:0] div_reg, div_next;
    logic [7:0]  rem_reg, rem_next;
    logic        dneg_reg, dneg_next;
    logic [TOTAL_W-1:0] tot_reg, tot_next;
    logic        sat_reg, sat_next;
    result_t     res_reg, res_next;
    result_t     out_data_reg, out_data_next;

    // Combinational helpers
    logic [7:0]  dt_eff;
    logic [16:0] e_w;
    logic [17:0] diff_w;
    logic [17:0] sume_w;
    logic [17:0] add_p, sel_p;
    logic [18:0] add_d, sel_d;
    logic [18:0] add_s, sel_s;
    logic [40:0] add_i, sel_i;
    logic [25:0] ds_w;
    logic [40:0] s41_w;
    logic        ovf_w;
    logic [39:0] s40_w;
    logic [35:0] dd_w;
    logic [TOTAL_W-1:0] dval_w;
    logic [TOTAL_W-1:0] total_w;
    logic        tot_neg_w;
    logic        tot_gt_w;
    logic        tot_ge_w;

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // A zero period counts as one
    assign dt_eff = (period_reg == 8'd0) ? 8'd1 : period_reg;

    // Error terms, all exact
    assign e_w    = {setpoint_reg[15], setpoint_reg} - {temp_reg[15], temp_reg};
    assign diff_w = {e_w[16], e_w} - {prev_err_reg[16], prev_err_reg};
    assign sume_w = {e_w[16], e_w} + {prev_err_reg[16], prev_err_reg};

    // Shift-add multiplier steps: add signed multiplicand on LSB, shift right
    assign add_p = prod_p_reg[33:16] + {e_reg[16], e_reg};
    assign sel_p = prod_p_reg[0] ? add_p : prod_p_reg[33:16];
    assign add_d = prod_d_reg[34:16] + {diff_reg[17], diff_reg};
    assign sel_d = prod_d_reg[0] ? add_d : prod_d_reg[34:16];
    assign add_s = prod_s_reg[34:16] + {sume_reg[17], sume_reg};
    assign sel_s = prod_s_reg[0] ? add_s : prod_s_reg[34:16];
    assign add_i = prod_i_reg[56:16] + {integral_reg[39], integral_reg};
    assign sel_i = prod_i_reg[0] ? add_i : prod_i_reg[56:16];

    // Integral update with saturation to 40 bits
    assign ds_w  = prod_s_reg[25:0];
    assign s41_w = {integral_reg[39], integral_reg} + {{15{ds_w[25]}}, ds_w};
    assign ovf_w = s41_w[40] ^ s41_w[39];
    assign s40_w = ovf_w ? (s41_w[40] ? INT_MIN40 : INT_MAX40) : s41_w[39:0];

    // Derivative dividend 2*kd*diff
    assign dd_w = {prod_d_reg, 1'b0};

    // Final sum and clamp
    assign dval_w    = dneg_reg ? (TOTAL_W'(0) - {{(TOTAL_W-36){1'b0}}, div_reg})
                                : {{(TOTAL_W-36){1'b0}}, div_reg};
    assign total_w   = tot_reg + dval_w;
    assign tot_neg_w = total_w[TOTAL_W-1];
    assign tot_gt_w  = !tot_neg_w && (total_w > TOTAL_FULL);
    assign tot_ge_w  = !tot_neg_w && (total_w >= TOTAL_FULL);

    // Next-state logic
    always_comb
    begin
        logic [8:0]  r9;
        logic [7:0]  rem_v;
        logic [35:0] div_v;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        setpoint_next  = setpoint_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        kd_next        = kd_reg;
        period_next    = period_reg;
        prev_err_next  = prev_err_reg;
        integral_next  = integral_reg;
        out_valid_next = out_valid_reg && result_stall;
        temp_next      = temp_reg;
        first_next     = first_reg;
        e_next         = e_reg;
        diff_next      = diff_reg;
        sume_next      = sume_reg;
        prod_p_next    = prod_p_reg;
        prod_d_next    = prod_d_reg;
        prod_s_next    = prod_s_reg;
        prod_i_next    = prod_i_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        dneg_next      = dneg_reg;
        tot_next       = tot_reg;
        sat_next       = sat_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        r9             = 9'd0;
        rem_v          = rem_reg;
        div_v          = div_reg;

        // Register writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:     mode_next     = cfg_data[0];
                REG_SETPOINT: setpoint_next = cfg_data;
                REG_KP:       kp_next       = cfg_data;
                REG_KI:       ki_next       = cfg_data;
                REG_KD:       kd_next       = cfg_data;
                REG_PERIOD:   period_next   = cfg_data[7:0];
                default:      ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    temp_next  = sample.temperature;
                    first_next = sample.first_sample;
                    state_next = S_PREP;
                end
            end

            // Form error terms, or decide on-off directly
            S_PREP:
            begin
                if (mode_reg == MODE_ONOFF)
                begin
                    res_next.heat_command =
                        ($signed(temp_reg) > $signed(setpoint_reg)) ? 15'd0 : CMD_ONOFF_ON;
                    res_next.clamped = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    e_next        = e_w;
                    diff_next     = diff_w;
                    sume_next     = sume_w;
                    prev_err_next = e_w;
                    prod_p_next   = {18'd0, kp_reg};
                    prod_d_next   = {19'd0, kd_reg};
                    prod_s_next   = {19'd0, 8'd0, dt_eff};
                    cnt_next      = 5'd0;
                    state_next    = S_MUL1;
                end
            end

            // kp*e, kd*diff and dt*(e+prev), one multiplier bit per cycle
            S_MUL1:
            begin
                prod_p_next = {sel_p[17], sel_p, prod_p_reg[15:1]};
                prod_d_next = {sel_d[18], sel_d, prod_d_reg[15:1]};
                prod_s_next = {sel_s[18], sel_s, prod_s_reg[15:1]};
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_SUM;
                end
            end

            // Integral update, set up ki multiply and derivative divide
            S_SUM:
            begin
                prod_i_next = {41'd0, ki_reg};
                rem_next    = 8'd0;
                cnt_next    = 5'd0;
                if (first_reg)
                begin
                    integral_next = 40'd0;
                    sat_next      = 1'b0;
                    div_next      = 36'd0;
                    dneg_next     = 1'b0;
                end
                else
                begin
                    integral_next = s40_w;
                    sat_next      = ovf_w;
                    dneg_next     = dd_w[35];
                    div_next      = dd_w[35] ? (36'd0 - dd_w) : dd_w;
                end
                state_next = S_MUL2;
            end

            // ki*sum (16 steps) alongside the 2-bit restoring divide (18 steps)
            S_MUL2:
            begin
                if (!cnt_reg[4])
                begin
                    prod_i_next = {sel_i[40], sel_i, prod_i_reg[15:1]};
                end
                for (int k = 0; k < 2; k++)
                begin
                    r9    = {rem_v, div_v[35]};
                    div_v = {div_v[34:0], 1'b0};
                    if (r9 >= {1'b0, dt_eff})
                    begin
                        r9       = r9 - {1'b0, dt_eff};
                        div_v[0] = 1'b1;
                    end
                    rem_v = r9[7:0];
                end
                div_next = div_v;
                rem_next = rem_v;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_ADD;
                end
            end

            // P + I
            S_ADD:
            begin
                tot_next = {{(TOTAL_W-35){prod_p_reg[33]}}, prod_p_reg, 1'b0}
                         + {{(TOTAL_W-57){prod_i_reg[56]}}, prod_i_reg};
                state_next = S_FINAL;
            end

            // + D, then clamp to 0..100 percent
            S_FINAL:
            begin
                if (tot_neg_w)
                begin
                    res_next.heat_command = 15'd0;
                end
                else if (tot_ge_w)
                begin
                    res_next.heat_command = CMD_FULL;
                end
                else
                begin
                    res_next.heat_command = total_w[FRAC_SHIFT +: 15];
                end
                res_next.clamped = sat_reg || tot_neg_w || tot_gt_w;
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, configuration and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 5'd0;
            mode_reg      <= RST_MODE;
            setpoint_reg  <= RST_SETPOINT;
            kp_reg        <= RST_KP;
            ki_reg        <= RST_KI;
            kd_reg        <= RST_KD;
            period_reg    <= RST_PERIOD;
            prev_err_reg  <= 17'd0;
            integral_reg  <= 40'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mode_reg      <= mode_next;
            setpoint_reg  <= setpoint_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            kd_reg        <= kd_next;
            period_reg    <= period_next;
            prev_err_reg  <= prev_err_next;
            integral_reg  <= integral_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        temp_reg     <= temp_next;
        first_reg    <= first_next;
        e_reg        <= e_next;
        diff_reg     <= diff_next;
        sume_reg     <= sume_next;
        prod_p_reg   <= prod_p_next;
        prod_d_reg   <= prod_d_next;
        prod_s_reg   <= prod_s_next;
        prod_i_reg   <= prod_i_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        dneg_reg     <= dneg_next;
        tot_reg      <= tot_next;
        sat_reg      <= sat_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- src/hpr_checker.sv -----
// ----------------------------------------------------------------------------
// Heater regulator port checker
// Watches the sample and result channels of the regulator over time.
// ----------------------------------------------------------------------------
`include "heater_pid_onoff_regulator_assert.svh"

module hpr_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    input  logic              sample_stall,
    input  logic              result_valid,
    input  logic              result_stall,
    input  hpr_pkg::result_t  result
);

    import hpr_pkg::*;

    // One sample in flight: an accepted transaction makes the block busy
    `HPR_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall, "sample accepted but block not busy")

    // Command never leaves 0..100 percent
    `HPR_ASSERT_SAME(a_cmd_range, result_valid, result.heat_command <= CMD_FULL, "heat command above 100 percent")

    // A new result only comes out of a busy block
    `HPR_ASSERT_SAME(a_result_from_work, $rose(result_valid), $past(sample_stall), "result appeared without work in progress")

    // Stalled result transaction holds
    `HPR_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(result), "stalled result dropped or changed")

endmodule

bind heater_pid_onoff_regulator hpr_checker u_hpr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
